/* sv/rational_arithmetic_unit_top_defines.svh */
// assertion macros shared by the rational arithmetic unit modules
// no dependencies; included by the modules that carry assertions
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rau_pkg.sv */
// types, widths, codes and helpers for the rational arithmetic unit
// no dependencies; used by the interfaces and modules through scoped names
package rau_pkg;

    // input field width and derived internal widths
    localparam int IN_W   = 16;
    localparam int PROD_W = 2 * IN_W;
    localparam int MAG_W  = 2 * IN_W + 1;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 31;
    localparam int EXT_W  = (MAG_W > NUM_W) ? MAG_W : NUM_W;
    localparam int K_W    = $clog2(MAG_W + 1);
    localparam int CNT_W  = $clog2(MAG_W);

    typedef logic [IN_W-1:0]  in_word_t;
    typedef logic [MAG_W-1:0] mag_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // datapath commands issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_COMB,
        DP_GCD,
        DP_GSET,
        DP_DIVN_INIT,
        DP_DIV_STEP,
        DP_DIVD_INIT,
        DP_FINISH
    } dp_cmd_t;

    // status returned to the controller
    typedef struct packed {
        logic gcd_done;
        logic div_last;
        logic err;
    } dp_status_t;

    // magnitude of a two's complement field (most negative value maps to 2^(IN_W-1))
    function automatic in_word_t mag_of(input in_word_t v);
        in_word_t r;
        r = v[IN_W-1] ? in_word_t'(~v + in_word_t'(1)) : v;
        return r;
    endfunction

endpackage

/* sv/rau_if.sv */
// request and response channel interfaces of the rational arithmetic unit
// depends on rau_pkg for field widths
interface rau_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic signed [rau_pkg::IN_W-1:0] a_num;
    logic signed [rau_pkg::IN_W-1:0] a_den;
    logic signed [rau_pkg::IN_W-1:0] b_num;
    logic signed [rau_pkg::IN_W-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [rau_pkg::NUM_W-1:0] res_num;
    logic [rau_pkg::DEN_W-1:0]        res_den;
    logic                             div_error;

    modport source (output valid, res_num, res_den, div_error, input ready);
    modport sink   (input valid, res_num, res_den, div_error, output ready);
endinterface

/* sv/rau_datapath.sv */
// datapath: operand registers, shared multiplier, sign-magnitude adder,
// binary gcd unit and restoring divider; depends on rau_pkg and the defines header
`include "rational_arithmetic_unit_top_defines.svh"

module rau_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rau_pkg::dp_cmd_t           dp_cmd,
    output rau_pkg::dp_status_t        status,
    input  logic [1:0]                 cmd,
    input  logic [rau_pkg::IN_W-1:0]   a_num,
    input  logic [rau_pkg::IN_W-1:0]   a_den,
    input  logic [rau_pkg::IN_W-1:0]   b_num,
    input  logic [rau_pkg::IN_W-1:0]   b_den,
    output logic [rau_pkg::NUM_W-1:0]  res_num,
    output logic [rau_pkg::DEN_W-1:0]  res_den,
    output logic                       div_error
);

    // operand registers (sign and magnitude)
    rau_pkg::op_t      op_reg;
    rau_pkg::in_word_t an_reg, ad_reg, bn_reg, bd_reg;
    logic              an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;

    // products
    rau_pkg::mag_t     p1_reg, p2_reg, pd_reg;
    logic              p1_neg_reg, p2_neg_reg, pd_neg_reg;

    // combined fraction
    rau_pkg::mag_t     num_reg, den_reg;
    logic              num_neg_reg, den_neg_reg;

    // gcd and divider state
    rau_pkg::mag_t            u_reg, v_reg, g_reg, rem_reg, q_reg, nq_reg;
    logic [rau_pkg::K_W-1:0]  k_reg;
    logic [rau_pkg::CNT_W-1:0] cnt_reg;

    // result registers
    logic [rau_pkg::NUM_W-1:0] res_num_reg;
    logic [rau_pkg::DEN_W-1:0] res_den_reg;
    logic                      err_reg;

    // shared multiplier operand select
    rau_pkg::in_word_t          mul_a, mul_b;
    logic [rau_pkg::PROD_W-1:0] prod;
    always_comb
    begin
        case (dp_cmd)
            rau_pkg::DP_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::DP_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
        prod = rau_pkg::PROD_W'(mul_a) * rau_pkg::PROD_W'(mul_b);
    end

    // sign-magnitude add of the two cross products
    logic          p2_eff_neg;
    rau_pkg::mag_t sum_mag;
    logic          sum_neg;
    always_comb
    begin
        p2_eff_neg = p2_neg_reg ^ (op_reg == rau_pkg::OP_SUB);
        if (p1_neg_reg == p2_eff_neg)
        begin
            sum_mag = p1_reg + p2_reg;
            sum_neg = p1_neg_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_mag = p1_reg - p2_reg;
            sum_neg = p1_neg_reg;
        end
        else
        begin
            sum_mag = p2_reg - p1_reg;
            sum_neg = p2_eff_neg;
        end
    end

    // one binary gcd step
    rau_pkg::mag_t           u_step, v_step;
    logic [rau_pkg::K_W-1:0] k_step;
    always_comb
    begin
        u_step = u_reg;
        v_step = v_reg;
        k_step = k_reg;
        if (u_reg != '0)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_step = u_reg >> 1;
                v_step = v_reg >> 1;
                k_step = k_reg + rau_pkg::K_W'(1);
            end
            else if (!u_reg[0])
            begin
                u_step = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_step = v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_step = (u_reg - v_reg) >> 1;
            end
            else
            begin
                v_step = (v_reg - u_reg) >> 1;
            end
        end
    end

    // one restoring division step
    logic [rau_pkg::MAG_W:0] rem_shift;
    logic                    rem_ge;
    always_comb
    begin
        rem_shift = {rem_reg, q_reg[rau_pkg::MAG_W-1]};
        rem_ge    = (rem_shift >= {1'b0, g_reg});
    end

    // final sign and truncation
    logic                      error_now;
    logic                      res_neg;
    logic [rau_pkg::EXT_W-1:0] nq_ext, dq_ext, num_signed;
    always_comb
    begin
        error_now  = (ad_reg == '0) || (bd_reg == '0) ||
                     ((op_reg == rau_pkg::OP_DIV) && (bn_reg == '0));
        res_neg    = (num_neg_reg != den_neg_reg) && (nq_reg != '0);
        nq_ext     = rau_pkg::EXT_W'(nq_reg);
        dq_ext     = rau_pkg::EXT_W'(q_reg);
        num_signed = res_neg ? (~nq_ext + rau_pkg::EXT_W'(1)) : nq_ext;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (dp_cmd)
            rau_pkg::DP_LOAD:
            begin
                op_reg     <= rau_pkg::op_t'(cmd);
                an_reg     <= rau_pkg::mag_of(a_num);
                ad_reg     <= rau_pkg::mag_of(a_den);
                bn_reg     <= rau_pkg::mag_of(b_num);
                bd_reg     <= rau_pkg::mag_of(b_den);
                an_neg_reg <= a_num[rau_pkg::IN_W-1];
                ad_neg_reg <= a_den[rau_pkg::IN_W-1];
                bn_neg_reg <= b_num[rau_pkg::IN_W-1];
                bd_neg_reg <= b_den[rau_pkg::IN_W-1];
            end
            rau_pkg::DP_MUL0:
            begin
                p1_reg     <= rau_pkg::MAG_W'(prod);
                p1_neg_reg <= an_neg_reg ^
                              ((op_reg == rau_pkg::OP_MUL) ? bn_neg_reg : bd_neg_reg);
            end
            rau_pkg::DP_MUL1:
            begin
                p2_reg     <= rau_pkg::MAG_W'(prod);
                p2_neg_reg <= bn_neg_reg ^ ad_neg_reg;
            end
            rau_pkg::DP_MUL2:
            begin
                pd_reg     <= rau_pkg::MAG_W'(prod);
                pd_neg_reg <= ad_neg_reg ^ bd_neg_reg;
            end
            rau_pkg::DP_COMB:
            begin
                // numerator and denominator by operation, gcd operands loaded too
                if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB)
                begin
                    num_reg     <= sum_mag;
                    num_neg_reg <= sum_neg;
                    u_reg       <= sum_mag;
                end
                else
                begin
                    num_reg     <= p1_reg;
                    num_neg_reg <= p1_neg_reg;
                    u_reg       <= p1_reg;
                end
                if (op_reg == rau_pkg::OP_DIV)
                begin
                    den_reg     <= p2_reg;
                    den_neg_reg <= p2_neg_reg;
                    v_reg       <= p2_reg;
                end
                else
                begin
                    den_reg     <= pd_reg;
                    den_neg_reg <= pd_neg_reg;
                    v_reg       <= pd_reg;
                end
                k_reg <= '0;
            end
            rau_pkg::DP_GCD:
            begin
                u_reg <= u_step;
                v_reg <= v_step;
                k_reg <= k_step;
            end
            rau_pkg::DP_GSET:
            begin
                g_reg <= v_reg << k_reg;
            end
            rau_pkg::DP_DIVN_INIT:
            begin
                rem_reg <= '0;
                q_reg   <= num_reg;
                cnt_reg <= rau_pkg::CNT_W'(rau_pkg::MAG_W - 1);
            end
            rau_pkg::DP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rau_pkg::MAG_W'(rem_shift - {1'b0, g_reg})
                                  : rem_shift[rau_pkg::MAG_W-1:0];
                q_reg   <= {q_reg[rau_pkg::MAG_W-2:0], rem_ge};
                cnt_reg <= cnt_reg - rau_pkg::CNT_W'(1);
            end
            rau_pkg::DP_DIVD_INIT:
            begin
                nq_reg  <= q_reg;
                rem_reg <= '0;
                q_reg   <= den_reg;
                cnt_reg <= rau_pkg::CNT_W'(rau_pkg::MAG_W - 1);
            end
            rau_pkg::DP_FINISH:
            begin
                if (error_now)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= rau_pkg::DEN_W'(1);
                    err_reg     <= 1'b1;
                end
                else
                begin
                    res_num_reg <= num_signed[rau_pkg::NUM_W-1:0];
                    res_den_reg <= dq_ext[rau_pkg::DEN_W-1:0];
                    err_reg     <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // status and outputs
    assign status.gcd_done = (u_reg == '0);
    assign status.div_last = (cnt_reg == '0);
    assign status.err      = error_now;
    assign res_num         = res_num_reg;
    assign res_den         = res_den_reg;
    assign div_error       = err_reg;

    // gcd of a nonzero denominator is never zero
    `RAU_ASSERT_NXT(a_gcd_nonzero, clk, rst_n, dp_cmd == rau_pkg::DP_GSET, g_reg != '0, "gcd came out zero")
    // a reduced denominator is at least one
    `RAU_ASSERT_NXT(a_den_positive, clk, rst_n, dp_cmd == rau_pkg::DP_FINISH, res_den_reg != '0, "zero result denominator")

endmodule

/* sv/rau_ctrl.sv */
// controller state machine sequencing load, multiply, gcd, divide and output
// depends on rau_pkg and the defines header
`include "rational_arithmetic_unit_top_defines.svh"

module rau_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output rau_pkg::dp_cmd_t    dp_cmd,
    input  rau_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_GCD,
        S_GSET,
        S_DIVN_INIT,
        S_DIVN,
        S_DIVD_INIT,
        S_DIVD,
        S_FIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = rau_pkg::DP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd     = rau_pkg::DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.err ? S_FIN : S_MUL0;
            end
            S_MUL0:
            begin
                dp_cmd     = rau_pkg::DP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                dp_cmd     = rau_pkg::DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                dp_cmd     = rau_pkg::DP_MUL2;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                dp_cmd     = rau_pkg::DP_COMB;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                dp_cmd = rau_pkg::DP_GCD;
                if (status.gcd_done)
                begin
                    state_next = S_GSET;
                end
            end
            S_GSET:
            begin
                dp_cmd     = rau_pkg::DP_GSET;
                state_next = S_DIVN_INIT;
            end
            S_DIVN_INIT:
            begin
                dp_cmd     = rau_pkg::DP_DIVN_INIT;
                state_next = S_DIVN;
            end
            S_DIVN:
            begin
                dp_cmd = rau_pkg::DP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_DIVD_INIT;
                end
            end
            S_DIVD_INIT:
            begin
                dp_cmd     = rau_pkg::DP_DIVD_INIT;
                state_next = S_DIVD;
            end
            S_DIVD:
            begin
                dp_cmd = rau_pkg::DP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                dp_cmd     = rau_pkg::DP_FINISH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_DONE);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // never ready for a request while a response is pending
    `RAU_ASSERT_IMP(a_ready_excl, clk, rst_n, in_ready, !out_valid, "ready while response pending")
    // a taken response frees the unit on the next cycle
    `RAU_ASSERT_NXT(a_rsp_frees, clk, rst_n, out_valid && out_ready, in_ready, "not ready after response")
    // an erroneous request skips the arithmetic
    `RAU_ASSERT_NXT(a_err_skip, clk, rst_n, state_reg == S_CHECK && status.err, state_reg == S_FIN, "error did not skip to finish")

endmodule

/* sv/rational_arithmetic_unit_top.sv */
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result reduced by its gcd, sign on the numerator,
// denominator positive, zero as 0/1; a zero denominator or division by zero
// sets div_error with 0/1. One request is worked at a time; the two
// restoring divisions run over MAG_W = 2*IN_W+1 (33) bits after the binary
// gcd, and a request with an error skips the arithmetic.
// Depends on rau_pkg, rau_if, rau_ctrl and rau_datapath.
module rational_arithmetic_unit_top (
    input  logic    clk,
    input  logic    rst_n,
    rau_req_if.sink req,
    rau_rsp_if.source rsp
);

    rau_pkg::dp_cmd_t    dp_cmd;
    rau_pkg::dp_status_t status;

    // controller
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_cmd    (dp_cmd),
        .status    (status)
    );

    // datapath
    rau_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .status    (status),
        .cmd       (req.cmd),
        .a_num     (req.a_num),
        .a_den     (req.a_den),
        .b_num     (req.b_num),
        .b_den     (req.b_den),
        .res_num   (rsp.res_num),
        .res_den   (rsp.res_den),
        .div_error (rsp.div_error)
    );

endmodule
